[rtl/core/encoder_speed_meter_macros.svh]
// Assertion macros used by the encoder speed meter RTL.
`ifndef ENCODER_SPEED_METER_MACROS_SVH
`define ENCODER_SPEED_METER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ESM_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("esm check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ESM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("esm check failed: next-cycle implication");

`endif

[rtl/core/esm_pkg.sv]
package esm_pkg;

    // Request opcodes
    localparam logic [1:0] OP_EDGE_A = 2'd0;
    localparam logic [1:0] OP_EDGE_B = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PULSES_PER_WINDOW = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_POLLS     = 2'd1;
    localparam logic [1:0] CFG_SPEED_NUMERATOR   = 2'd2;

    localparam logic [15:0] PULSES_PER_WINDOW_RST = 16'd16;
    localparam logic [15:0] TIMEOUT_POLLS_RST     = 16'd500;
    localparam logic [31:0] SPEED_NUMERATOR_RST   = 32'd46875000;
    localparam logic [31:0] SPEED_RST             = 32'd100;
    localparam logic [31:0] SPEED_SAT             = 32'hFFFF_FFFF;
    localparam logic [15:0] IDLE_SAT              = 16'hFFFF;

    // Divider: one quotient bit per cycle over the 32-bit numerator
    localparam int NUM_W     = 32;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    typedef struct packed {
        logic [1:0]  op;
        logic        other_level;
        logic [31:0] time_us;
    } s_payload_t;

    typedef struct packed {
        logic [31:0]        speed_centi;
        logic               fresh;
        logic signed [31:0] position;
    } m_payload_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    typedef struct packed {
        logic edge_en;
        logic poll_en;
        logic div_step;
        logic push;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_need;
        logic div_last;
    } ctrl_sts_t;

endpackage

[rtl/core/esm_divider.sv]
module esm_divider #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         step,
    input  logic [esm_pkg::NUM_W-1:0]    numerator,
    input  logic [TIME_WIDTH-1:0]        divisor,
    output logic                         last,
    output logic [esm_pkg::NUM_W-1:0]    quot_next
);

    localparam logic [esm_pkg::DIV_CNT_W-1:0] CNT_LAST =
        esm_pkg::DIV_CNT_W'(esm_pkg::NUM_W - 1);

    logic [esm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [TIME_WIDTH-1:0]         rem_reg, rem_next;
    logic [TIME_WIDTH-1:0]         dsr_reg;
    logic [esm_pkg::NUM_W-1:0]     num_reg;
    logic [TIME_WIDTH:0]           trial, dsr_ext, sub;
    logic                          qbit;

    // Restoring step: shift in the next dividend bit, subtract when it fits
    assign trial   = {rem_reg, num_reg[esm_pkg::NUM_W-1]};
    assign dsr_ext = {1'b0, dsr_reg};
    assign qbit    = (trial >= dsr_ext);
    assign sub     = trial - dsr_ext;
    assign rem_next  = qbit ? sub[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
    assign quot_next = {num_reg[esm_pkg::NUM_W-2:0], qbit};
    assign last      = (cnt_reg == CNT_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= '0;
        end else if (step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            num_reg <= numerator;
        end else if (step) begin
            rem_reg <= rem_next;
            num_reg <= quot_next;
        end
    end

endmodule

[rtl/core/esm_datapath.sv]
module esm_datapath #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  esm_pkg::s_payload_t s_payload,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    input  esm_pkg::ctrl_cmd_t  cmd,
    output esm_pkg::ctrl_sts_t  sts,
    output esm_pkg::m_payload_t m_payload
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [15:0]            ppw_reg, tmo_reg;
    logic [31:0]            numer_reg;
    logic [COUNT_WIDTH-1:0] pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] ref_reg, ref_next;
    logic [TIME_WIDTH-1:0]  ws_reg, ws_next;
    logic [15:0]            idle_reg, idle_next;
    logic [31:0]            speed_reg, speed_next;
    logic                   fresh_reg, fresh_next;
    esm_pkg::m_payload_t    out_reg;

    logic [TIME_WIDTH+31:0]  now_ext;
    logic [TIME_WIDTH-1:0]   now, elapsed;
    logic [COUNT_WIDTH-1:0]  diff;
    logic [CMP_W+15:0]       diff_ext, ppw_ext;
    logic [COUNT_WIDTH+31:0] pos_sx;
    logic                    is_idle, is_close, is_timeout;
    logic [15:0]             idle_a, idle_b;
    logic [31:0]             quot_next;
    logic                    div_last;

    // Poll evaluation: idle check, then window check, then timeout check
    assign now_ext  = {{TIME_WIDTH{1'b0}}, s_payload.time_us};
    assign now      = now_ext[TIME_WIDTH-1:0];
    assign diff     = pos_reg - ref_reg;
    assign diff_ext = {{(16 + CMP_W - COUNT_WIDTH){1'b0}}, diff};
    assign ppw_ext  = {{CMP_W{1'b0}}, ppw_reg};
    assign is_idle  = (diff == '0);
    assign is_close = (diff_ext[CMP_W-1:0] == ppw_ext[CMP_W-1:0]);
    assign ws_next  = is_idle ? now : ws_reg;
    assign elapsed  = now - ws_next;
    assign idle_a   = is_idle ? ((idle_reg != esm_pkg::IDLE_SAT) ? idle_reg + 16'd1 : idle_reg)
                              : idle_reg;
    assign idle_b   = is_close ? 16'd0 : idle_a;
    assign is_timeout = (idle_b >= tmo_reg);

    assign sts.div_need = is_close && !is_timeout && (elapsed != '0);
    assign sts.div_last = div_last;

    always_comb begin
        pos_next   = pos_reg;
        ref_next   = ref_reg;
        idle_next  = idle_reg;
        speed_next = speed_reg;
        fresh_next = fresh_reg;
        if (cmd.edge_en) begin
            pos_next = s_payload.other_level ? pos_reg - 1'b1 : pos_reg + 1'b1;
        end
        if (cmd.poll_en) begin
            fresh_next = is_idle ? 1'b0 : fresh_reg;
            if (is_close) begin
                ref_next   = pos_reg;
                fresh_next = 1'b1;
                if (elapsed == '0) begin
                    speed_next = esm_pkg::SPEED_SAT;
                end
            end
            idle_next = idle_b;
            if (is_timeout) begin
                speed_next = '0;
                idle_next  = '0;
                fresh_next = 1'b1;
            end
        end
        if (cmd.div_step && div_last) begin
            speed_next = quot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppw_reg   <= esm_pkg::PULSES_PER_WINDOW_RST;
            tmo_reg   <= esm_pkg::TIMEOUT_POLLS_RST;
            numer_reg <= esm_pkg::SPEED_NUMERATOR_RST;
            pos_reg   <= '0;
            ref_reg   <= '0;
            ws_reg    <= '0;
            idle_reg  <= '0;
            speed_reg <= esm_pkg::SPEED_RST;
            fresh_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    esm_pkg::CFG_PULSES_PER_WINDOW: ppw_reg   <= cfg_wdata[15:0];
                    esm_pkg::CFG_TIMEOUT_POLLS:     tmo_reg   <= cfg_wdata[15:0];
                    esm_pkg::CFG_SPEED_NUMERATOR:   numer_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            pos_reg   <= pos_next;
            ref_reg   <= ref_next;
            idle_reg  <= idle_next;
            speed_reg <= speed_next;
            fresh_reg <= fresh_next;
            if (cmd.poll_en) begin
                ws_reg <= ws_next;
            end
        end
    end

    // Result register: capture the state once the poll has settled
    assign pos_sx = {{32{pos_reg[COUNT_WIDTH-1]}}, pos_reg};

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_reg.speed_centi <= speed_reg;
            out_reg.fresh       <= fresh_reg;
            out_reg.position    <= pos_sx[31:0];
        end
    end

    assign m_payload = out_reg;

    esm_divider #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (cmd.poll_en),
        .step      (cmd.div_step),
        .numerator (numer_reg),
        .divisor   (elapsed),
        .last      (div_last),
        .quot_next (quot_next)
    );

endmodule

[rtl/core/esm_ctrl.sv]
module esm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [1:0]         s_op,
    input  logic               m_ready,
    input  esm_pkg::ctrl_sts_t sts,
    output logic               s_ready,
    output logic               m_valid,
    output esm_pkg::ctrl_cmd_t cmd
);

    esm_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == esm_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            esm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_op)
                        esm_pkg::OP_EDGE_A, esm_pkg::OP_EDGE_B: cmd.edge_en = 1'b1;
                        esm_pkg::OP_POLL: begin
                            cmd.poll_en = 1'b1;
                            state_next  = sts.div_need ? esm_pkg::ST_DIV : esm_pkg::ST_PUSH;
                        end
                        default: ;  // drop the unused code
                    endcase
                end
            end
            esm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = esm_pkg::ST_PUSH;
                end
            end
            esm_pkg::ST_PUSH: begin
                if (out_free) begin
                    cmd.push   = 1'b1;
                    state_next = esm_pkg::ST_IDLE;
                end
            end
            default: state_next = esm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= esm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[rtl/core/encoder_speed_meter.sv]
// Quadrature encoder position counter with period-based speed measurement.
// Input channel (s_valid/s_ready, s_payload): each request is a rising edge
// on channel A or B (moves the signed position) or a timed poll. Edges give
// no result; every poll gives one result on the output channel
// (m_valid/m_ready, m_payload): speed in hundredths, fresh flag, position.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write window size, idle
// timeout and speed numerator in one cycle; write only while idle.
// Timing: an edge request is taken without leaving idle. A poll that closes a
// window with nonzero elapsed time runs the iterative divider, one quotient bit
// per cycle over the 32-bit numerator, then loads the result register once it
// is free; m_valid rises in the cycle after that load, and the next request is
// taken once the sequencer is back in idle. Other polls load the result
// register directly, with no divider steps.
// The single divider sets the throughput; nothing is accepted while it runs.
// Stall: the result register holds its result until m_ready; edges are still
// accepted meanwhile, and a following poll waits for the register to empty.
// Reset (aresetn low, synchronous): registers return to their defaults,
// position and reference clear, speed reads one, nothing is pending.
module encoder_speed_meter #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  esm_pkg::s_payload_t s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output esm_pkg::m_payload_t m_payload,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);

`include "encoder_speed_meter_macros.svh"

    esm_pkg::ctrl_cmd_t cmd;
    esm_pkg::ctrl_sts_t sts;

    // Sequencer: accept, divide, push the result
    esm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_payload.op),
        .m_ready (m_ready),
        .sts     (sts),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    // Counters, window state, config registers, divider and result register
    esm_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_payload (m_payload)
    );

    // No request is taken while the divider iterates
    `ESM_ASSERT_IMPLY(a_no_accept_in_div, aclk, aresetn, cmd.div_step, !s_ready)
    // Load the result register only when it is empty or being drained
    `ESM_ASSERT_IMPLY(a_push_when_free, aclk, aresetn, cmd.push, (!m_valid || m_ready))
    // A pushed result is offered in the next cycle
    `ESM_ASSERT_NEXT(a_push_shows_valid, aclk, aresetn, cmd.push, m_valid)

endmodule

[test/encoder_speed_meter_checker.sv]
module encoder_speed_meter_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  esm_pkg::s_payload_t s_payload,
    input  logic                m_valid,
    input  logic                m_ready,
    input  esm_pkg::m_payload_t m_payload,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOW_MAX = 10;

    // Shadow copy of the meter: registers and state
    logic [15:0] win_size;
    logic [15:0] idle_limit;
    logic [31:0] numer;
    logic [31:0] pos_cnt;
    logic [31:0] ref_cnt;
    logic [31:0] win_start;
    logic [15:0] idle_cnt;
    logic [31:0] speed_q;
    logic        fresh_q;

    esm_pkg::m_payload_t speed_reports[$];
    int                  shown;

    // Apply one request to the shadow state; return 1 when it yields a report.
    function automatic bit meter_step(input esm_pkg::s_payload_t req,
                                      output esm_pkg::m_payload_t rpt);
        logic [31:0] diff;
        logic [31:0] elapsed;
        rpt = '0;
        case (req.op)
            esm_pkg::OP_EDGE_A, esm_pkg::OP_EDGE_B: begin
                pos_cnt = req.other_level ? pos_cnt - 32'd1 : pos_cnt + 32'd1;
                return 1'b0;
            end
            esm_pkg::OP_POLL: begin
                diff = pos_cnt - ref_cnt;
                if (diff == 32'd0) begin
                    fresh_q   = 1'b0;
                    win_start = req.time_us;
                    if (idle_cnt != esm_pkg::IDLE_SAT)
                        idle_cnt = idle_cnt + 16'd1;
                end
                if (diff == {16'd0, win_size}) begin
                    elapsed = req.time_us - win_start;
                    speed_q = (elapsed == 32'd0) ? esm_pkg::SPEED_SAT : numer / elapsed;
                    fresh_q = 1'b1;
                    ref_cnt = pos_cnt;
                    idle_cnt = '0;
                end
                if (idle_cnt >= idle_limit) begin
                    speed_q  = '0;
                    idle_cnt = '0;
                    fresh_q  = 1'b1;
                end
                rpt.speed_centi = speed_q;
                rpt.fresh       = fresh_q;
                rpt.position    = pos_cnt;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge aclk) begin
        esm_pkg::m_payload_t want;
        if (!aresetn) begin
            win_size   = esm_pkg::PULSES_PER_WINDOW_RST;
            idle_limit = esm_pkg::TIMEOUT_POLLS_RST;
            numer      = esm_pkg::SPEED_NUMERATOR_RST;
            pos_cnt    = '0;
            ref_cnt    = '0;
            win_start  = '0;
            idle_cnt   = '0;
            speed_q    = esm_pkg::SPEED_RST;
            fresh_q    = 1'b0;
            speed_reports.delete();
            errors     = 0;
            shown      = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    esm_pkg::CFG_PULSES_PER_WINDOW: win_size   = cfg_wdata[15:0];
                    esm_pkg::CFG_TIMEOUT_POLLS:     idle_limit = cfg_wdata[15:0];
                    esm_pkg::CFG_SPEED_NUMERATOR:   numer      = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (speed_reports.size() == 0) begin
                    errors++;
                    if (shown < SHOW_MAX) begin
                        shown++;
                        $display("%0t: unexpected report speed=%0d fresh=%0b pos=%0d",
                                 $realtime, m_payload.speed_centi,
                                 m_payload.fresh, m_payload.position);
                    end
                end else begin
                    want = speed_reports.pop_front();
                    if (m_payload.speed_centi !== want.speed_centi ||
                        m_payload.fresh !== want.fresh ||
                        m_payload.position !== want.position) begin
                        errors++;
                        if (shown < SHOW_MAX) begin
                            shown++;
                            // speed/fresh/position
                            $display("%0t: mismatch exp %0d/%0b/%0d got %0d/%0b/%0d",
                                     $realtime, want.speed_centi, want.fresh,
                                     want.position, m_payload.speed_centi,
                                     m_payload.fresh, m_payload.position);
                        end
                    end
                end
            end
            if (s_valid && s_ready && meter_step(s_payload, want))
                speed_reports.push_back(want);
        end
        pending = speed_reports.size();
    end

endmodule

[test/encoder_speed_meter_tb.sv]
module encoder_speed_meter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Op code the block ignores; no name for it exists in the package
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Cycles without any handshake or register write before the run is abandoned
    localparam int STALL_LIMIT = 3000;
    // Settle time after the last report, long enough for a poll that divides
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS = 290;
    localparam int SPECIAL_ITEMS = 80;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    esm_pkg::s_payload_t s_payload;
    logic                m_valid;
    logic                m_ready;
    esm_pkg::m_payload_t m_payload;
    logic                cfg_wr_en;
    logic [1:0]          cfg_index;
    logic [31:0]         cfg_wdata;
    int                  mismatches;
    int                  outstanding;

    // Stimulus bookkeeping: net edges since the last closed window, as the
    // sender sees it, so that well-formed windows can be lined up
    int          net_cnt;
    logic [15:0] cur_ppw;
    logic [31:0] now_us;
    int          items_sent;
    bit          gaps_on;

    encoder_speed_meter uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    encoder_speed_meter_checker speed_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .errors    (mismatches),
        .pending   (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offer one request and hold it until the block takes it. Drop valid for a
    // random burst first when gaps are enabled.
    task automatic send_req(input logic [1:0] op, input logic lvl, input logic [31:0] t);
        esm_pkg::s_payload_t req;
        req.op          = op;
        req.other_level = lvl;
        req.time_us     = t;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (op == esm_pkg::OP_EDGE_A || op == esm_pkg::OP_EDGE_B)
            net_cnt += lvl ? -1 : 1;
        else if (op == esm_pkg::OP_POLL && net_cnt == int'(cur_ppw))
            net_cnt = 0;
    endtask

    // One encoder edge on a random channel; the time stamp is don't-care here
    task automatic step_count(input logic down);
        send_req(($urandom_range(0, 1) != 0) ? esm_pkg::OP_EDGE_B : esm_pkg::OP_EDGE_A,
                 down, $urandom());
    endtask

    // A poll; the level bit is don't-care, so randomize it
    task automatic poll_at(input logic [31:0] t);
        send_req(esm_pkg::OP_POLL, $urandom_range(0, 1) != 0, t);
    endtask

    // Drain the block, let it settle, then write all three registers
    task automatic program_meter(input logic [15:0] ppw, input logic [15:0] tmo,
                                 input logic [31:0] num);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= esm_pkg::CFG_PULSES_PER_WINDOW;
        cfg_wdata <= {16'd0, ppw};
        @(posedge aclk);
        cfg_index <= esm_pkg::CFG_TIMEOUT_POLLS;
        cfg_wdata <= {16'd0, tmo};
        @(posedge aclk);
        cfg_index <= esm_pkg::CFG_SPEED_NUMERATOR;
        cfg_wdata <= num;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_ppw = ppw;
    endtask

    // Well-formed measurement window with random content: realign, open the
    // window with an idle poll, advance the count, then close it after a span
    // drawn from zero, one, short, long or a full wrap. One in five windows
    // is deliberately off by one edge.
    task automatic run_window();
        int          target;
        logic [31:0] span;
        while (net_cnt != 0) step_count(net_cnt > 0);
        poll_at(now_us);
        repeat ($urandom_range(0, 2)) begin
            now_us += $urandom_range(1, 5000);
            poll_at(now_us);
        end
        target = int'(cur_ppw);
        case ($urandom_range(0, 9))
            0: target += 1;
            1: target -= 1;
            default: ;
        endcase
        while (net_cnt < target) begin
            // jitter: back one, forward one
            if ($urandom_range(0, 7) == 0) begin
                step_count(1'b1);
                step_count(1'b0);
            end
            step_count(1'b0);
            if (net_cnt < target && $urandom_range(0, 7) == 0)
                poll_at(now_us + $urandom_range(1, 100));
        end
        case ($urandom_range(0, 5))
            0: span = '0;
            1: span = 32'd1;
            2: span = $urandom_range(2, 1000);
            3: span = $urandom_range(1001, 2000000);
            default: span = $urandom();
        endcase
        now_us += span;
        poll_at(now_us);
        if ($urandom_range(0, 3) == 0) begin
            now_us += $urandom_range(0, 100);
            poll_at(now_us);
        end
    endtask

    // Result side: random ready bursts, one long hold-off to back the block up
    initial begin : report_sink
        int reports_taken;
        bit pressed;
        reports_taken = 0;
        pressed       = 1'b0;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                reports_taken++;
            if (!pressed && reports_taken >= 150 && s_valid) begin
                // hold off long enough that a poll blocks the input channel
                pressed = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abandon the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                quiet = 0;
            else
                quiet++;
        end
        $display("** encoder_speed_meter: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int          phase_end;
        int          pick;
        logic [15:0] ppw;
        logic [15:0] tmo;
        logic [31:0] num;
        logic [1:0]  rop;

        net_cnt    = 0;
        cur_ppw    = esm_pkg::PULSES_PER_WINDOW_RST;
        now_us     = '0;
        items_sent = 0;
        gaps_on    = 1'b1;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= esm_pkg::CFG_PULSES_PER_WINDOW;
        cfg_wdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: idle poll at time zero, ignored op, moves both ways,
        // a poll with the count below the reference, then one full window
        poll_at('0);
        send_req(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
        send_req(esm_pkg::OP_EDGE_A, 1'b1, 32'hFFFF_FFFF);
        send_req(esm_pkg::OP_EDGE_B, 1'b0, '0);
        send_req(esm_pkg::OP_EDGE_B, 1'b1, 32'h5555_5555);
        poll_at(32'd5);
        send_req(esm_pkg::OP_EDGE_A, 1'b0, 32'hAAAA_AAAA);
        for (int i = 0; i < 16; i++)
            send_req(i[0] ? esm_pkg::OP_EDGE_B : esm_pkg::OP_EDGE_A, 1'b0, $urandom());
        poll_at(32'd46875);

        // Small window: time wrap, zero elapsed time, idle timeout
        program_meter(16'd2, 16'd3, 32'd1000);
        poll_at(32'hFFFF_FFF0);
        step_count(1'b0);
        step_count(1'b0);
        poll_at(32'h0000_0010);
        poll_at(32'd100);
        step_count(1'b0);
        step_count(1'b0);
        poll_at(32'd100);
        repeat (3) poll_at(32'd200);

        // Zero window size: every idle poll closes a window with zero time
        program_meter(16'd0, 16'd5, 32'd7);
        poll_at(32'd50);
        poll_at(32'd60);
        now_us = 32'd60;

        // Random phases; the special settings with a zero or very large window get short phases without windows
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: program_meter(16'd1, 16'd1, 32'd1);
                1: program_meter(16'hFFFF, 16'hFFFF, esm_pkg::SPEED_SAT);
                2: program_meter(16'd0, 16'd0, esm_pkg::SPEED_NUMERATOR_RST);
                default: begin
                    ppw = 16'($urandom_range(1, 12));
                    tmo = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 10));
                    case ($urandom_range(0, 3))
                        0: num = $urandom_range(1, 1000);
                        1: num = esm_pkg::SPEED_NUMERATOR_RST;
                        2: num = esm_pkg::SPEED_SAT;
                        default: num = $urandom();
                    endcase
                    program_meter(ppw, tmo, num);
                end
            endcase
            // no gaps in the last phase; some earlier phases run flat out too
            gaps_on   = (ph != 6) && ($urandom_range(0, 3) != 0);
            phase_end = items_sent + ((ph == 1 || ph == 2) ? SPECIAL_ITEMS : RANDOM_ITEMS);
            while (items_sent < phase_end) begin
                if (cur_ppw == 16'd0 || cur_ppw > 16'd64)
                    pick = $urandom_range(7, 9);
                else
                    pick = $urandom_range(0, 9);
                case (pick)
                    7: begin
                        // run of idle polls to reach the timeout
                        if ($urandom_range(0, 3) != 0)
                            while (net_cnt != 0) step_count(net_cnt > 0);
                        repeat ($urandom_range(1, 12)) begin
                            now_us += $urandom_range(0, 3000);
                            poll_at(now_us);
                        end
                    end
                    8, 9: begin
                        repeat ($urandom_range(1, 4)) begin
                            rop = 2'($urandom());
                            send_req(rop, $urandom_range(0, 1) != 0, $urandom());
                        end
                    end
                    default: run_window();
                endcase
            end
        end

        // Drain and settle, then give the verdict
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("** encoder_speed_meter: PASSED **");
        else
            $display("** encoder_speed_meter: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/esm_pkg.sv
rtl/core/esm_divider.sv
rtl/core/esm_datapath.sv
rtl/core/esm_ctrl.sv
rtl/core/encoder_speed_meter.sv
test/encoder_speed_meter_checker.sv
test/encoder_speed_meter_tb.sv
